[rtl/rfor_pkg.sv]
// ----------------------------------------------------------------------------
// rfor_pkg: shared types and constants of the rectangle rasterizer
// Canvas geometry, item codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package rfor_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = $clog2(MAX_COLUMNS * MAX_ROWS);

  // width of a used-area size, wide enough for the register and the limit
  localparam int CFG_W  = 8;
  localparam int XW     = ((COL_W > ROW_W ? COL_W : ROW_W) + 1 > CFG_W) ?
                          ((COL_W > ROW_W ? COL_W : ROW_W) + 1) : CFG_W;

  // geometry: 24-bit signed fixed point, 8 fraction bits, sums need two more
  localparam int COORD_W  = 24;
  localparam int FRAC_W   = 8;
  localparam int GW       = COORD_W + 2;
  localparam int ONE_UNIT = 1 << FRAC_W;

  localparam logic [7:0] SHAPE_OUTLINE = 8'h72;
  localparam logic [7:0] SHAPE_FILLED  = 8'h52;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_BG     = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 8'd128;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 8'd128;
  localparam logic [CFG_W-1:0] RST_BG     = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } st_t;

  // sequencer to geometry unit
  typedef struct packed {
    logic capture;  // load rectangle and first bounds
    logic setup;    // derive inner bounds
  } geom_ctl_t;

endpackage

[rtl/rfor_canvas.sv]
// ----------------------------------------------------------------------------
// rfor_canvas: canvas byte store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfor_canvas
  import rfor_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MAX_COLUMNS*MAX_ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rfor_geom.sv]
// ----------------------------------------------------------------------------
// rfor_geom: rectangle coverage unit
// Holds the rectangle bounds and tests one pixel per cycle against them.
// ----------------------------------------------------------------------------
module rfor_geom
  import rfor_pkg::*;
(
  input  logic                      clk,
  input  geom_ctl_t                 ctl,
  input  logic signed [COORD_W-1:0] rect_left,
  input  logic signed [COORD_W-1:0] rect_top,
  input  logic signed [COORD_W-1:0] rect_span_x,
  input  logic signed [COORD_W-1:0] rect_span_y,
  input  logic                      filled,
  input  logic [COL_W-1:0]          col,
  input  logic [ROW_W-1:0]          row,
  output logic                      hit
);

  logic signed [GW-1:0] left_r, top_r, right_r, bottom_r;
  logic signed [GW-1:0] lin_r, tin_r, rin_r, bin_r;
  logic signed [GW-1:0] px, py;
  logic                 covered, border;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      left_r   <= GW'(rect_left);
      top_r    <= GW'(rect_top);
      right_r  <= GW'(rect_left) + GW'(rect_span_x);
      bottom_r <= GW'(rect_top) + GW'(rect_span_y);
      lin_r    <= GW'(rect_left) + GW'(ONE_UNIT);
      tin_r    <= GW'(rect_top) + GW'(ONE_UNIT);
    end
    if (ctl.setup) begin
      rin_r <= right_r - GW'(ONE_UNIT);
      bin_r <= bottom_r - GW'(ONE_UNIT);
    end
  end

  // pixel centers sit on whole units
  assign px = $signed({{(GW-COL_W-FRAC_W){1'b0}}, col, {FRAC_W{1'b0}}});
  assign py = $signed({{(GW-ROW_W-FRAC_W){1'b0}}, row, {FRAC_W{1'b0}}});

  always_comb begin
    covered = (px >= left_r) && (px <= right_r) && (py >= top_r) && (py <= bottom_r);
    // less than one unit from any edge
    border  = (px < lin_r) || (px > rin_r) || (py < tin_r) || (py > bin_r);
    hit     = covered && (border || filled);
  end

endmodule

[rtl/rfor_seq.sv]
// ----------------------------------------------------------------------------
// rfor_seq: item sequencer
// Decodes items, sweeps the canvas one pixel a cycle, reads single pixels
// and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rfor_seq
  import rfor_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_shape_code,
  input  logic              in_span_ok,
  input  logic [7:0]        in_paint_byte,
  input  logic [6:0]        in_read_column,
  input  logic [6:0]        in_read_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [7:0]        out_pixel_byte,
  input  logic [CFG_W-1:0]  cfg_width,
  input  logic [CFG_W-1:0]  cfg_height,
  input  logic [7:0]        cfg_bg,
  output geom_ctl_t         geom_ctl,
  output logic              filled,
  output logic [COL_W-1:0]  col,
  output logic [ROW_W-1:0]  row,
  input  logic              hit,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data
);

  st_t              state_r, state_nxt;
  logic             clear_r, clear_nxt;
  logic             filled_r, filled_nxt;
  logic [7:0]       paint_r, paint_nxt;
  logic [6:0]       rcol_r, rcol_nxt;
  logic [6:0]       rrow_r, rrow_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             res_status_r, res_status_nxt;
  logic [7:0]       res_pixel_r, res_pixel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [7:0]       out_pixel_r, out_pixel_nxt;

  logic [XW-1:0]    ucols, urows;
  logic             empty, last_col, last_row, accept, shape_ok, rd_in_range;

  // used area, saturated to the canvas size
  always_comb begin
    ucols = (XW'(cfg_width) > XW'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS) : XW'(cfg_width);
    urows = (XW'(cfg_height) > XW'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(cfg_height);
    empty = (ucols == '0) || (urows == '0);
    last_col = (XW'(col_r) == ucols - XW'(1));
    last_row = (XW'(row_r) == urows - XW'(1));
    rd_in_range = (XW'(rcol_r) < ucols) && (XW'(rrow_r) < urows);
    shape_ok = (in_shape_code == SHAPE_OUTLINE) || (in_shape_code == SHAPE_FILLED);
  end

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clear_nxt      = clear_r;
    filled_nxt     = filled_r;
    paint_nxt      = paint_r;
    rcol_nxt       = rcol_r;
    rrow_nxt       = rrow_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    res_status_nxt = res_status_r;
    res_pixel_nxt  = res_pixel_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pixel_nxt  = out_pixel_r;
    geom_ctl       = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    // drop the result word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          geom_ctl.capture = 1'b1;
          clear_nxt      = (in_kind == KIND_CLEAR);
          filled_nxt     = (in_shape_code == SHAPE_FILLED);
          paint_nxt      = in_paint_byte;
          rcol_nxt       = in_read_column;
          rrow_nxt       = in_read_row;
          col_nxt        = '0;
          row_nxt        = '0;
          res_status_nxt = 1'b0;
          res_pixel_nxt  = '0;
          case (in_kind)
            KIND_CLEAR: state_nxt = empty ? ST_FINISH : ST_SWEEP;
            KIND_DRAW: begin
              if (!in_span_ok || !shape_ok) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_FINISH;
              end else begin
                state_nxt = ST_SETUP;
              end
            end
            KIND_READ: state_nxt = ST_READ;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        geom_ctl.setup = 1'b1;
        state_nxt      = empty ? ST_FINISH : ST_SWEEP;
      end
      ST_SWEEP: begin
        wr_en = clear_r || hit;
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
          if (last_row) begin
            state_nxt = ST_FINISH;
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        res_pixel_nxt = rd_in_range ? rd_data : 8'd0;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pixel_nxt  = res_pixel_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clear_r      <= clear_nxt;
    filled_r     <= filled_nxt;
    paint_r      <= paint_nxt;
    rcol_r       <= rcol_nxt;
    rrow_r       <= rrow_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    res_status_r <= res_status_nxt;
    res_pixel_r  <= res_pixel_nxt;
    out_status_r <= out_status_nxt;
    out_pixel_r  <= out_pixel_nxt;
  end

  assign filled         = filled_r;
  assign col            = col_r;
  assign row            = row_r;
  assign wr_addr        = ADDR_W'(row_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col_r);
  assign wr_data        = clear_r ? cfg_bg : paint_r;
  assign rd_addr        = ADDR_W'(rrow_r[ROW_W-1:0]) * ADDR_W'(MAX_COLUMNS)
                          + ADDR_W'(rcol_r[COL_W-1:0]);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pixel_byte = out_pixel_r;

endmodule

[rtl/rect_fill_outline_raster_top.sv]
// ----------------------------------------------------------------------------
// rect_fill_outline_raster_top: character canvas rasterizer
// Clears the canvas, draws outlined or filled rectangles, reads pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry one item: clear, draw or read.
//   Each item gives exactly one result word (out_valid / out_stall):
//   out_status is 1 for a rejected rectangle, out_pixel_byte the read pixel.
//   The block works on one item at a time and stalls input while busy.
//   A sweep visits the used area W x H one pixel per cycle and writes the
//   covered pixels (all of them for a clear) through the canvas write port.
//   The result word sits in an output register; the next item is accepted
//   while it waits, and that item's result waits until the word is taken.
//   cfg_wr_en writes canvas_width, canvas_height or background_byte;
//   write only while idle. Sizes above 128 saturate, zero gives no sweep.
//   Synchronous reset (rst_n low) empties the output register and sets the
//   sizes to 128 and the background to 32. Canvas contents are undefined
//   until the first clear.
// ----------------------------------------------------------------------------
module rect_fill_outline_raster_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_shape_code,
  input  logic signed [23:0]         in_rect_left,
  input  logic signed [23:0]         in_rect_top,
  input  logic signed [23:0]         in_rect_span_x,
  input  logic signed [23:0]         in_rect_span_y,
  input  logic [7:0]                 in_paint_byte,
  input  logic [6:0]                 in_read_column,
  input  logic [6:0]                 in_read_row,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [7:0]                 out_pixel_byte,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_wdata
);
  import rfor_pkg::*;

  logic [CFG_W-1:0]  width_r, height_r, bg_r;
  geom_ctl_t         geom_ctl;
  logic              filled, hit, span_ok;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      bg_r     <= RST_BG;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        CFG_IDX_BG:     bg_r     <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // both spans must be strictly positive
  assign span_ok = !in_rect_span_x[23] && (in_rect_span_x != '0) &&
                   !in_rect_span_y[23] && (in_rect_span_y != '0);

  rfor_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_shape_code  (in_shape_code),
    .in_span_ok     (span_ok),
    .in_paint_byte  (in_paint_byte),
    .in_read_column (in_read_column),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_pixel_byte (out_pixel_byte),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .cfg_bg         (bg_r),
    .geom_ctl       (geom_ctl),
    .filled         (filled),
    .col            (col),
    .row            (row),
    .hit            (hit),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  rfor_geom u_geom (
    .clk         (clk),
    .ctl         (geom_ctl),
    .rect_left   (in_rect_left),
    .rect_top    (in_rect_top),
    .rect_span_x (in_rect_span_x),
    .rect_span_y (in_rect_span_y),
    .filled      (filled),
    .col         (col),
    .row         (row),
    .hit         (hit)
  );

  rfor_canvas u_canvas (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[rtl/rfor_checker.sv]
// ----------------------------------------------------------------------------
// rfor_checker: port-level checks of the rasterizer
// Watches the channel ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rfor_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_status,
  input logic [7:0] out_pixel_byte
);

  // reset leaves an empty output and a ready input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // a rejected rectangle never carries a pixel
  a_reject_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_pixel_byte == 8'd0)
    else $error("pixel byte on rejected word");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_pixel_byte))
    else $error("stalled result word changed");

endmodule

bind rect_fill_outline_raster_top rfor_checker u_rfor_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_pixel_byte (out_pixel_byte)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rectangle fill and outline rasterizer
// Sends clear, draw, read and unknown items through the valid/stall input
// port. Each accepted item is run through a behavioral canvas model kept
// here, and each result word is compared in order against it. Both sides
// idle at random. One phase holds the result side off long enough to back
// up the input. Canvas size and background registers are changed between
// phases, including zero and saturating sizes.
// ----------------------------------------------------------------------------
module tb_top;
  import rfor_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_SETTLE  = 4;
  localparam int END_SETTLE   = 32;
  localparam int RUN_LIMIT_NS = 25_000_000;
  localparam int MAX_PRINTED  = 100;

  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         shape_code;
    logic signed [23:0] rect_left;
    logic signed [23:0] rect_top;
    logic signed [23:0] rect_span_x;
    logic signed [23:0] rect_span_y;
    logic [7:0]         paint_byte;
    logic [6:0]         read_column;
    logic [6:0]         read_row;
  } raster_item_t;

  typedef struct {
    logic       status;
    logic [7:0] pixel_byte;
  } raster_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic [7:0]         in_shape_code;
  logic signed [23:0] in_rect_left;
  logic signed [23:0] in_rect_top;
  logic signed [23:0] in_rect_span_x;
  logic signed [23:0] in_rect_span_y;
  logic [7:0]         in_paint_byte;
  logic [6:0]         in_read_column;
  logic [6:0]         in_read_row;
  logic               out_valid;
  logic               out_stall;
  logic               out_status;
  logic [7:0]         out_pixel_byte;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_wdata;

  // canvas model and its registers
  logic [7:0] canvas_img [MAX_COLUMNS*MAX_ROWS];
  logic [7:0] mdl_width  = RST_WIDTH;
  logic [7:0] mdl_height = RST_HEIGHT;
  logic [7:0] mdl_bg     = RST_BG;

  raster_result_t pending_raster_results[$];

  int  items_sent      = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  mismatch_count  = 0;
  int  in_stall_cycles = 0;
  bit  tx_idle_on      = 1'b1;
  bit  rx_idle_on      = 1'b1;
  int  rx_hold_req     = 0;

  rect_fill_outline_raster_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_shape_code  (in_shape_code),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_span_x (in_rect_span_x),
    .in_rect_span_y (in_rect_span_y),
    .in_paint_byte  (in_paint_byte),
    .in_read_column (in_read_column),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_pixel_byte (out_pixel_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int size_limit(input logic [7:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // Update the canvas model with one item and return the word it gives.
  function automatic raster_result_t raster_predict(input raster_item_t it);
    raster_result_t res;
    int     cols;
    int     rows;
    longint left;
    longint top;
    longint right;
    longint bottom;
    longint px;
    longint py;
    bit     filled;
    bit     border;
    res.status     = 1'b0;
    res.pixel_byte = 8'h00;
    cols = size_limit(mdl_width, MAX_COLUMNS);
    rows = size_limit(mdl_height, MAX_ROWS);
    case (it.kind)
      KIND_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            canvas_img[r*MAX_COLUMNS + c] = mdl_bg;
      end
      KIND_DRAW: begin
        if (it.rect_span_x <= 0 || it.rect_span_y <= 0 ||
            (it.shape_code != SHAPE_OUTLINE && it.shape_code != SHAPE_FILLED)) begin
          res.status = 1'b1;
        end else begin
          left   = it.rect_left;
          top    = it.rect_top;
          right  = left + longint'(it.rect_span_x);
          bottom = top + longint'(it.rect_span_y);
          filled = (it.shape_code == SHAPE_FILLED);
          for (int r = 0; r < rows; r++) begin
            py = longint'(r) * ONE_UNIT;
            for (int c = 0; c < cols; c++) begin
              px = longint'(c) * ONE_UNIT;
              if (px >= left && px <= right && py >= top && py <= bottom) begin
                // border: closer than one unit to any edge
                border = (px - left < ONE_UNIT) || (right - px < ONE_UNIT) ||
                         (py - top < ONE_UNIT) || (bottom - py < ONE_UNIT);
                if (border || filled) canvas_img[r*MAX_COLUMNS + c] = it.paint_byte;
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (int'(it.read_column) < cols && int'(it.read_row) < rows)
          res.pixel_byte = canvas_img[int'(it.read_row)*MAX_COLUMNS + int'(it.read_column)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic raster_item_t random_fields();
    raster_item_t it;
    it.kind        = 2'($urandom_range(0, 3));
    it.shape_code  = 8'($urandom);
    it.rect_left   = 24'($urandom);
    it.rect_top    = 24'($urandom);
    it.rect_span_x = 24'($urandom);
    it.rect_span_y = 24'($urandom);
    it.paint_byte  = 8'($urandom);
    it.read_column = 7'($urandom);
    it.read_row    = 7'($urandom);
    return it;
  endfunction

  // position a little around the used area, half of them on whole units
  function automatic logic signed [23:0] rand_coord(input int units);
    int v;
    v = $urandom_range(0, (units + 4) * ONE_UNIT) - 2 * ONE_UNIT;
    if ($urandom_range(0, 1)) v = v - (v % ONE_UNIT);
    return 24'(v);
  endfunction

  function automatic logic signed [23:0] rand_span(input int units);
    int v;
    v = $urandom_range(1, (units + 2) * ONE_UNIT);
    if ($urandom_range(0, 1)) v = $urandom_range(1, units + 2) * ONE_UNIT;
    return 24'(v);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input raster_item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_shape_code  <= it.shape_code;
    in_rect_left   <= it.rect_left;
    in_rect_top    <= it.rect_top;
    in_rect_span_x <= it.rect_span_x;
    in_rect_span_y <= it.rect_span_y;
    in_paint_byte  <= it.paint_byte;
    in_read_column <= it.read_column;
    in_read_row    <= it.read_row;
    // hold the word until the block takes it
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_raster_results.push_back(raster_predict(it));
    items_sent++;
  endtask

  task automatic send_clear();
    raster_item_t it;
    it      = random_fields();
    it.kind = KIND_CLEAR;
    send_item(it);
  endtask

  task automatic send_read(input logic [6:0] col, input logic [6:0] row);
    raster_item_t it;
    it             = random_fields();
    it.kind        = KIND_READ;
    it.read_column = col;
    it.read_row    = row;
    send_item(it);
  endtask

  task automatic send_draw(input logic [7:0] shape, input logic signed [23:0] left,
                           input logic signed [23:0] top, input logic signed [23:0] sx,
                           input logic signed [23:0] sy, input logic [7:0] paint);
    raster_item_t it;
    it             = random_fields();
    it.kind        = KIND_DRAW;
    it.shape_code  = shape;
    it.rect_left   = left;
    it.rect_top    = top;
    it.rect_span_x = sx;
    it.rect_span_y = sy;
    it.paint_byte  = paint;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_raster_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_IDX_WIDTH:  mdl_width  = val;
      CFG_IDX_HEIGHT: mdl_height = val;
      CFG_IDX_BG:     mdl_bg     = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Full clear first: every pixel is defined from here on.
  task automatic test_clear_full();
    send_clear();
    send_read(7'd0, 7'd0);
    send_read(7'd127, 7'd127);
  endtask

  task automatic test_draw_modes();
    // filled, fractional left and width
    send_draw(SHAPE_FILLED, 24'sd640, 24'sd256, 24'sd1344, 24'sd768, 8'h41);
    send_read(7'd4, 7'd2);
    send_read(7'd2, 7'd2);
    // outline on whole units: edges fall exactly on pixel centers
    send_draw(SHAPE_OUTLINE, 24'sd2560, 24'sd2560, 24'sd1024, 24'sd1024, 8'hFF);
    send_read(7'd12, 7'd12);
    send_read(7'd14, 7'd12);
  endtask

  task automatic test_rejects();
    raster_item_t it;
    send_draw(SHAPE_FILLED, 24'sd0, 24'sd0, 24'sd0, 24'sd512, 8'h55);
    send_draw(SHAPE_OUTLINE, 24'sd0, 24'sd0, 24'sd512, 24'sh800000, 8'h55);
    send_draw(8'h00, 24'sd0, 24'sd0, 24'sd512, 24'sd512, 8'h55);
    send_draw(8'hFF, 24'sd0, 24'sd0, 24'sd512, 24'sd512, 8'h55);
    it      = random_fields();
    it.kind = KIND_UNUSED;
    send_item(it);
    send_read(7'd1, 7'd1);
  endtask

  task automatic test_coord_extremes();
    // right edge lands at -1: nothing covered
    send_draw(SHAPE_FILLED, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 8'h11);
    send_draw(SHAPE_OUTLINE, 24'sh7FFFFF, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 8'h22);
    // covers the whole canvas, no border in reach
    send_draw(SHAPE_FILLED, -24'sd256, -24'sd256, 24'sh7FFFFF, 24'sh7FFFFF, 8'h00);
    send_read(7'd0, 7'd0);
    send_read(7'd127, 7'd127);
  endtask

  task automatic test_canvas_sizes();
    write_reg(CFG_IDX_WIDTH, 8'd0);
    send_clear();
    send_read(7'd0, 7'd0);
    write_reg(CFG_IDX_WIDTH, 8'd200);
    write_reg(CFG_IDX_HEIGHT, 8'd1);
    write_reg(CFG_IDX_BG, 8'd255);
    send_clear();
    send_read(7'd127, 7'd0);
    send_read(7'd0, 7'd1);
    write_reg(CFG_IDX_HEIGHT, 8'd0);
    send_draw(SHAPE_FILLED, 24'sd0, 24'sd0, 24'sd2048, 24'sd2048, 8'h77);
  endtask

  // Result side stops for a long stretch while input keeps coming.
  task automatic test_backpressure();
    write_reg(CFG_IDX_WIDTH, 8'd8);
    write_reg(CFG_IDX_HEIGHT, 8'd6);
    tx_idle_on = 1'b0;
    send_clear();
    rx_hold_req = 300;
    for (int k = 0; k < 10; k++) begin
      if (k % 3 == 1)
        send_draw(SHAPE_OUTLINE, rand_coord(8), rand_coord(6), rand_span(8), rand_span(6),
                  8'($urandom));
      else
        send_read(7'($urandom_range(0, 7)), 7'($urandom_range(0, 5)));
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_scenes();
    raster_item_t it;
    int           w;
    int           h;
    int           eff_w;
    int           eff_h;
    int           pick;
    logic [7:0]   bg;
    for (int s = 0; s < 8; s++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
      if (s == 2) begin
        w = $urandom_range(129, 255);
        h = $urandom_range(1, 4);
      end else if (s == 5) begin
        if ($urandom_range(0, 1)) w = 0; else h = 0;
      end
      bg = 8'($urandom);
      if (s == 0) bg = 8'h00;
      else if ($urandom_range(0, 3) == 0) bg = 8'hFF;
      write_reg(CFG_IDX_WIDTH, 8'(w));
      write_reg(CFG_IDX_HEIGHT, 8'(h));
      write_reg(CFG_IDX_BG, bg);
      eff_w = size_limit(8'(w), MAX_COLUMNS);
      eff_h = size_limit(8'(h), MAX_ROWS);
      if ($urandom_range(0, 9) < 7) send_clear();
      for (int k = 0; k < 8; k++) begin
        pick = $urandom_range(0, 99);
        it   = random_fields();
        if (pick < 80) begin
          it.rect_left   = rand_coord(eff_w);
          it.rect_top    = rand_coord(eff_h);
          it.rect_span_x = rand_span(eff_w);
          it.rect_span_y = rand_span(eff_h);
          it.shape_code  = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
        end
        if (pick < 35) begin
          it.kind = KIND_DRAW;
        end else if (pick < 75) begin
          it.kind = KIND_READ;
          // mostly inside the used area
          if (eff_w > 0 && $urandom_range(0, 6) != 0)
            it.read_column = 7'($urandom_range(0, eff_w - 1));
          if (eff_h > 0 && $urandom_range(0, 6) != 0)
            it.read_row = 7'($urandom_range(0, eff_h - 1));
        end else if (pick < 80) begin
          it.kind = KIND_CLEAR;
        end else if (pick < 90) begin
          it.kind = KIND_DRAW;
          case ($urandom_range(0, 2))
            0: it.rect_span_x = $urandom_range(0, 1) ? 24'sd0 : {1'b1, 23'($urandom)};
            1: it.rect_span_y = $urandom_range(0, 1) ? 24'sd0 : {1'b1, 23'($urandom)};
            default: begin
              do it.shape_code = 8'($urandom);
              while (it.shape_code == SHAPE_OUTLINE || it.shape_code == SHAPE_FILLED);
            end
          endcase
        end
        // the rest goes out with every field random
        send_item(it);
      end
    end
  endtask

  // result side: random hold-off per word, or a long one on request
  initial begin : rx_side
    int n;
    forever begin
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin : result_check
    raster_result_t want;
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b1) in_stall_cycles++;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_raster_results.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = pending_raster_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("word %0d status %b, want %b",
                                  results_checked, out_status, want.status));
        if (out_pixel_byte !== want.pixel_byte)
          flag_mismatch($sformatf("word %0d pixel_byte %h, want %h",
                                  results_checked, out_pixel_byte, want.pixel_byte));
        results_checked++;
      end
    end
  end

  initial begin
    in_valid       <= 1'b0;
    in_kind        <= KIND_CLEAR;
    in_shape_code  <= 8'h00;
    in_rect_left   <= 24'sd0;
    in_rect_top    <= 24'sd0;
    in_rect_span_x <= 24'sd0;
    in_rect_span_y <= 24'sd0;
    in_paint_byte  <= 8'h00;
    in_read_column <= 7'd0;
    in_read_row    <= 7'd0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_IDX_WIDTH;
    cfg_wdata      <= 8'h00;
    rst_n          <= 1'b0;
    for (int i = 0; i < MAX_COLUMNS*MAX_ROWS; i++) canvas_img[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clear_full();
    test_draw_modes();
    test_rejects();
    test_coord_extremes();
    test_canvas_sizes();
    test_backpressure();
    test_random_scenes();

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_raster_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_raster_results.size()));
    $display("Ran %0d items (clear, draw, read, unknown, rejected) and %0d register writes;",
             items_sent, reg_writes);
    $display("compared %0d result words, input held back for %0d cycles, %0d mismatches.",
             results_checked, in_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results outstanding", pending_raster_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[rect_fill_outline_raster_top.f]
rtl/rfor_pkg.sv
rtl/rfor_canvas.sv
rtl/rfor_geom.sv
rtl/rfor_seq.sv
rtl/rect_fill_outline_raster_top.sv
rtl/rfor_checker.sv
verif/tb_top.sv
